@@ rtl/mspd_pkg.sv @@
// ----------------------------------------------------------------------------
// mspd_pkg
// Shared types and codes for the serial reply deframer.
// ----------------------------------------------------------------------------
package mspd_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLY_DIR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_CMD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd4;

    // register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd36;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd77;
    localparam logic [BYTE_W-1:0] REPLY_DIR_RST   = 8'd62;
    localparam logic [BYTE_W-1:0] EXP_CMD_RST     = 8'd0;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd255;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_CSUM  = 3'd1,
        ST_DIR   = 3'd2,
        ST_CMD   = 3'd3,
        ST_SIZE  = 3'd4
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] reply_direction;
        logic [BYTE_W-1:0] expected_command;
        logic [BYTE_W-1:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic              has_byte;
        logic              frame_done;
        status_t           status;
        logic [BYTE_W-1:0] frame_size;
    } result_t;

endpackage

@@ rtl/mspd_fsm.sv @@
// ----------------------------------------------------------------------------
// mspd_fsm
// Frame phase tracking, checksum accumulation and result forming per byte.
// ----------------------------------------------------------------------------
module mspd_fsm
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [mspd_pkg::BYTE_W-1:0] rx_byte,
    input  mspd_pkg::cfg_t            cfg,
    output mspd_pkg::result_t         res
);
    import mspd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_DIR     = 3'd2,
        PH_SIZE    = 3'd3,
        PH_CMD     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] size_reg, size_next;
    logic [BYTE_W-1:0] seen_reg, seen_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] seen_inc;

    assign seen_inc = seen_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        size_next  = size_reg;
        seen_next  = seen_reg;
        xor_next   = xor_reg;
        res        = '0;
        res.status = ST_OK;
        unique case (phase_reg)
            PH_HUNT2:
            begin
                if (rx_byte == cfg.sync_second)
                    phase_next = PH_DIR;
                else if (rx_byte != cfg.sync_first)
                    phase_next = PH_HUNT1;
            end
            PH_DIR:
            begin
                size_next = '0;
                seen_next = '0;
                xor_next  = '0;
                if (rx_byte != cfg.reply_direction)
                begin
                    phase_next     = PH_HUNT1;
                    res.valid      = 1'b1;
                    res.frame_done = 1'b1;
                    res.status     = ST_DIR;
                end
                else
                    phase_next = PH_SIZE;
            end
            PH_SIZE:
            begin
                size_next = rx_byte;
                xor_next  = rx_byte;
                if (rx_byte > cfg.max_payload)
                begin
                    phase_next     = PH_HUNT1;
                    res.valid      = 1'b1;
                    res.frame_done = 1'b1;
                    res.status     = ST_SIZE;
                    res.frame_size = rx_byte;
                end
                else
                    phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                xor_next  = xor_reg ^ rx_byte;
                seen_next = '0;
                if (rx_byte != cfg.expected_command)
                begin
                    phase_next     = PH_HUNT1;
                    res.valid      = 1'b1;
                    res.frame_done = 1'b1;
                    res.status     = ST_CMD;
                    res.frame_size = size_reg;
                end
                else
                    phase_next = (size_reg == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                xor_next  = xor_reg ^ rx_byte;
                seen_next = seen_inc;
                if (seen_inc == size_reg)
                    phase_next = PH_CHECK;
                res.valid         = 1'b1;
                res.payload_byte  = rx_byte;
                res.payload_index = seen_reg;
                res.has_byte      = 1'b1;
                res.frame_size    = size_reg;
            end
            PH_CHECK:
            begin
                phase_next     = PH_HUNT1;
                res.valid      = 1'b1;
                res.frame_done = 1'b1;
                res.status     = (rx_byte == xor_reg) ? ST_OK : ST_CSUM;
                res.frame_size = size_reg;
            end
            default:
            begin
                // hunt, also taken by the unused phase code
                phase_next = (rx_byte == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            size_reg  <= '0;
            seen_reg  <= '0;
            xor_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            seen_reg  <= seen_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

@@ rtl/msp_reply_deframer_top.sv @@
// ----------------------------------------------------------------------------
// msp_reply_deframer_top
// Serial reply deframer: preamble hunt, header checks, payload and checksum.
// ----------------------------------------------------------------------------
// output: a result shows in the cycle after its causing byte is taken
// throughput: one byte per cycle unless stalled (single-step phase update)
// the input is stalled only while a result waits in the output register
// and the output side stalls
// reset: phase goes to preamble hunt; registers but out_reg take defaults
module msp_reply_deframer_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mspd_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mspd_pkg::BYTE_W-1:0]   payload_byte,
    output logic [mspd_pkg::BYTE_W-1:0]   payload_index,
    output logic                          has_byte,
    output logic                          frame_done,
    output logic [mspd_pkg::STATUS_W-1:0] status,
    output logic [mspd_pkg::BYTE_W-1:0]   frame_size,
    input  logic                          cfg_we,
    input  logic [mspd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mspd_pkg::BYTE_W-1:0]   cfg_data
);
    import mspd_pkg::*;

    cfg_t    cfg_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;
    logic    step;

    assign in_stall = out_valid_reg & out_stall;
    assign step     = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first       <= SYNC_FIRST_RST;
            cfg_reg.sync_second      <= SYNC_SECOND_RST;
            cfg_reg.reply_direction  <= REPLY_DIR_RST;
            cfg_reg.expected_command <= EXP_CMD_RST;
            cfg_reg.max_payload      <= MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:  cfg_reg.sync_first       <= cfg_data;
                REG_SYNC_SECOND: cfg_reg.sync_second      <= cfg_data;
                REG_REPLY_DIR:   cfg_reg.reply_direction  <= cfg_data;
                REG_EXP_CMD:     cfg_reg.expected_command <= cfg_data;
                REG_MAX_PAYLOAD: cfg_reg.max_payload      <= cfg_data;
                default:         ;
            endcase
        end
    end

    mspd_fsm u_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx_byte),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        if (step && res.valid)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload holds unless a new item replaces it
    always_ff @(posedge clk)
    begin
        if (step && res.valid)
            out_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = out_reg.payload_byte;
    assign payload_index = out_reg.payload_index;
    assign has_byte      = out_reg.has_byte;
    assign frame_done    = out_reg.frame_done;
    assign status        = out_reg.status;
    assign frame_size    = out_reg.frame_size;

endmodule
